>>> rtl/rbcs_pkg.sv
package rbcs_pkg;

    localparam int FUNC_W = 1;
    localparam int CMD_W  = 4;
    localparam int BG_W   = 2;
    localparam int BK_W   = 2;
    localparam int ROW_W  = 17;
    localparam int MODE_W = 2;

    typedef logic [CMD_W-1:0]  cmd_code_t;
    typedef logic [MODE_W-1:0] mode_t;

    localparam logic [FUNC_W-1:0] FUNC_QUERY = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_ISSUE = 1'b1;

    localparam cmd_code_t CMD_ACT  = 4'd0;
    localparam cmd_code_t CMD_PRE  = 4'd1;
    localparam cmd_code_t CMD_PREA = 4'd2;
    localparam cmd_code_t CMD_RD   = 4'd3;
    localparam cmd_code_t CMD_WR   = 4'd4;
    localparam cmd_code_t CMD_RDA  = 4'd5;
    localparam cmd_code_t CMD_WRA  = 4'd6;
    localparam cmd_code_t CMD_REF  = 4'd7;
    localparam cmd_code_t CMD_PDE  = 4'd8;
    localparam cmd_code_t CMD_PDX  = 4'd9;
    localparam cmd_code_t CMD_SRE  = 4'd10;
    localparam cmd_code_t CMD_SRX  = 4'd11;
    localparam cmd_code_t CMD_NONE = 4'd12;

    localparam mode_t MODE_UP  = 2'd0;
    localparam mode_t MODE_APD = 2'd1;
    localparam mode_t MODE_PPD = 2'd2;
    localparam mode_t MODE_SR  = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } ctl_state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;
        logic execute;
    } dp_ctrl_t;

endpackage

>>> rtl/rbcs_if.sv
interface rbcs_req_if;
    import rbcs_pkg::*;

    logic                valid;
    logic                ready;
    logic [FUNC_W-1:0]   func;
    logic [CMD_W-1:0]    cmd;
    logic [BG_W-1:0]     group_sel;
    logic [BK_W-1:0]     bank;
    logic [ROW_W-1:0]    row;

    modport source (output valid, func, cmd, group_sel, bank, row, input ready);
    modport sink   (input valid, func, cmd, group_sel, bank, row, output ready);
endinterface

interface rbcs_rsp_if;
    import rbcs_pkg::*;

    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    next_cmd;
    logic                error;
    logic [MODE_W-1:0]   rank_mode;
    logic                bank_is_open;

    modport source (output valid, next_cmd, error, rank_mode, bank_is_open, input ready);
    modport sink   (input valid, next_cmd, error, rank_mode, bank_is_open, output ready);
endinterface

>>> rtl/rbcs_ram.sv
module rbcs_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 16
) (
    input  logic                             clk,
    input  logic                             wr_en,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                 wr_data,
    input  logic                             rd_en,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
    output logic [WIDTH-1:0]                 rd_data
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

>>> rtl/rbcs_ctrl.sv
module rbcs_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    input  logic               rsp_ready,
    output logic               req_ready,
    output logic               rsp_valid,
    output rbcs_pkg::dp_ctrl_t ctrl
);
    import rbcs_pkg::*;

    ctl_state_t state_reg, state_next;
    logic       rsp_valid_reg, rsp_valid_next;
    logic       rsp_free;

    // The output register is free when empty or being drained this cycle
    assign rsp_free     = !rsp_valid_reg || rsp_ready;
    assign req_ready    = (state_reg == ST_IDLE);
    assign ctrl.capture = req_valid && (state_reg == ST_IDLE);
    assign ctrl.execute = (state_reg == ST_EXEC) && rsp_free;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (rsp_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (ctrl.execute)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
endmodule

>>> rtl/rbcs_datapath.sv
module rbcs_datapath #(
    parameter int BANK_GROUPS     = 4,
    parameter int BANKS_PER_GROUP = 4,
    parameter int ROW_BITS        = 17
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rbcs_pkg::dp_ctrl_t            ctrl,
    input  logic [rbcs_pkg::FUNC_W-1:0]   func,
    input  logic [rbcs_pkg::CMD_W-1:0]    cmd,
    input  logic [rbcs_pkg::BG_W-1:0]     group_sel,
    input  logic [rbcs_pkg::BK_W-1:0]     bank,
    input  logic [rbcs_pkg::ROW_W-1:0]    row,
    output logic [rbcs_pkg::CMD_W-1:0]    next_cmd,
    output logic                          error,
    output logic [rbcs_pkg::MODE_W-1:0]   rank_mode,
    output logic                          bank_is_open
);
    import rbcs_pkg::*;

    localparam int NBANKS = BANK_GROUPS * BANKS_PER_GROUP;
    localparam int IDX_W  = $clog2(NBANKS > 1 ? NBANKS : 2);

    // Captured item
    logic [FUNC_W-1:0]   func_reg;
    cmd_code_t           cmd_reg;
    logic                valid_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [ROW_BITS-1:0] row_reg;

    logic                in_valid;
    logic [IDX_W-1:0]    in_idx;

    // Rank and bank state
    mode_t               mode_reg, mode_next;
    logic [NBANKS-1:0]   open_flags_reg, open_flags_next;

    logic [ROW_BITS-1:0] open_row;
    logic                ram_wr_en;
    logic                is_open, any_open;
    cmd_code_t           result_cmd;
    logic                result_err;

    // Output register
    cmd_code_t           next_cmd_reg;
    logic                error_reg;
    mode_t               rank_mode_reg;
    logic                bank_is_open_reg;

    // Out-of-range bank address names no bank and maps to entry zero
    assign in_valid = (int'(group_sel) < BANK_GROUPS) && (int'(bank) < BANKS_PER_GROUP);
    assign in_idx   = in_valid
                    ? IDX_W'(int'(group_sel) * BANKS_PER_GROUP + int'(bank))
                    : '0;

    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            func_reg  <= func;
            cmd_reg   <= cmd;
            valid_reg <= in_valid;
            idx_reg   <= in_idx;
            row_reg   <= ROW_BITS'(row);
        end
    end

    assign ram_wr_en = ctrl.execute && (func_reg == FUNC_ISSUE)
                    && (cmd_reg == CMD_ACT) && valid_reg;

    // Row store is read at capture, so the row is ready in the execute cycle
    rbcs_ram #(
        .WIDTH (ROW_BITS),
        .DEPTH (NBANKS)
    ) u_row_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (idx_reg),
        .wr_data (row_reg),
        .rd_en   (ctrl.capture),
        .rd_addr (in_idx),
        .rd_data (open_row)
    );

    assign is_open  = valid_reg && open_flags_reg[idx_reg];
    assign any_open = |open_flags_reg;

    always_comb
    begin
        result_cmd      = CMD_NONE;
        result_err      = 1'b0;
        mode_next       = mode_reg;
        open_flags_next = open_flags_reg;
        if (func_reg == FUNC_QUERY)
        begin
            case (cmd_reg)
                CMD_RD, CMD_WR:
                begin
                    if (mode_reg inside {MODE_APD, MODE_PPD})
                    begin
                        result_cmd = CMD_PDX;
                    end
                    else if (mode_reg == MODE_SR)
                    begin
                        result_cmd = CMD_SRX;
                    end
                    else if (!is_open)
                    begin
                        result_cmd = CMD_ACT;
                    end
                    else if (open_row == row_reg)
                    begin
                        result_cmd = cmd_reg;
                    end
                    else
                    begin
                        result_cmd = CMD_PRE;
                    end
                end
                CMD_REF:
                begin
                    result_cmd = any_open ? CMD_PREA : CMD_REF;
                end
                CMD_PDE:
                begin
                    result_cmd = (mode_reg == MODE_SR) ? CMD_SRX : CMD_PDE;
                end
                CMD_SRE:
                begin
                    result_cmd = (mode_reg inside {MODE_APD, MODE_PPD}) ? CMD_PDX : CMD_SRE;
                end
                default:
                begin
                    result_err = 1'b1;
                end
            endcase
        end
        else
        begin
            case (cmd_reg)
                CMD_ACT:
                begin
                    if (valid_reg)
                    begin
                        open_flags_next[idx_reg] = 1'b1;
                    end
                end
                CMD_PRE, CMD_RDA, CMD_WRA:
                begin
                    if (valid_reg)
                    begin
                        open_flags_next[idx_reg] = 1'b0;
                    end
                end
                CMD_PREA:
                begin
                    open_flags_next = '0;
                end
                CMD_PDE:
                begin
                    mode_next = any_open ? MODE_APD : MODE_PPD;
                end
                CMD_PDX, CMD_SRX:
                begin
                    mode_next = MODE_UP;
                end
                CMD_SRE:
                begin
                    mode_next = MODE_SR;
                end
                default:
                begin
                    mode_next = mode_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_UP;
            open_flags_reg <= '0;
        end
        else if (ctrl.execute)
        begin
            mode_reg       <= mode_next;
            open_flags_reg <= open_flags_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.execute)
        begin
            next_cmd_reg     <= result_cmd;
            error_reg        <= result_err;
            rank_mode_reg    <= mode_next;
            bank_is_open_reg <= valid_reg && open_flags_next[idx_reg];
        end
    end

    assign next_cmd     = next_cmd_reg;
    assign error        = error_reg;
    assign rank_mode    = rank_mode_reg;
    assign bank_is_open = bank_is_open_reg;
endmodule

>>> rtl/ddr4_rank_bank_command_state.sv
// DDR4 rank and bank command state tracker.
//
// req channel: one item per handshake (valid and ready high at a clock edge).
//   func 0 asks which command must go out before cmd for the addressed bank;
//   func 1 applies cmd to the rank and bank state.
// rsp channel: one item per request, in order: next_cmd (none for issue
//   items and for queries without a rule), error, the rank mode after the
//   item and whether the addressed bank is open after the item.
// Timing: an item is captured at the accept edge, the row store is read in
//   the same edge, and the result is computed and registered in the output
//   register once that register is free, which raises rsp.valid. A new item
//   is accepted only after the last one has executed, as set by the
//   controller's capture-then-execute sequence around the registered row store read.
// Stall: while rsp.ready is low and a result waits, the next item is still
//   accepted and held in the capture stage; it is executed once the output
//   register frees up.
// Reset: rst_n clears the rank to powered up and every bank to closed. The
//   row store is not cleared; a row is consulted only while its bank is open.
module ddr4_rank_bank_command_state #(
    parameter int BANK_GROUPS     = 4,
    parameter int BANKS_PER_GROUP = 4,
    parameter int ROW_BITS        = 17
) (
    input  logic        clk,
    input  logic        rst_n,
    rbcs_req_if.sink    req,
    rbcs_rsp_if.source  rsp
);
    import rbcs_pkg::*;

    dp_ctrl_t ctrl;

    rbcs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .rsp_ready (rsp.ready),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .ctrl      (ctrl)
    );

    rbcs_datapath #(
        .BANK_GROUPS     (BANK_GROUPS),
        .BANKS_PER_GROUP (BANKS_PER_GROUP),
        .ROW_BITS        (ROW_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .func         (req.func),
        .cmd          (req.cmd),
        .group_sel    (req.group_sel),
        .bank         (req.bank),
        .row          (req.row),
        .next_cmd     (rsp.next_cmd),
        .error        (rsp.error),
        .rank_mode    (rsp.rank_mode),
        .bank_is_open (rsp.bank_is_open)
    );

    // An executed item shows up on the output next cycle
    a_exec_to_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.execute |=> rsp.valid)
        else $error("executed item did not reach the output");

    // Only one item in flight in the capture stage
    a_single_capture: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("second item accepted before execute");

    // A query without a rule carries no prerequisite command
    a_error_none: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.error |-> rsp.next_cmd == CMD_NONE)
        else $error("error result with a command code");

    // Execute never fires while a result is stalled
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.ready |-> !ctrl.execute)
        else $error("output register overwritten under stall");
endmodule
